>>> rtl/core/etl_pkg.sv
// ============================================================================
// etl_pkg - shared types and constants of the expression token lexer
// Byte classes, token kinds, status codes, pending-token states and the
// transaction structs passed between the front, back and result queue.
// ============================================================================
`default_nettype none

package etl_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int BYTE_Q_DEPTH      = 4;
  localparam int RES_Q_DEPTH       = 4;
  localparam int VALUE_BITS        = 63;

  // Byte classes, decided in the front.
  typedef enum logic [3:0] {
    BC_DIGIT = 4'd0,
    BC_SPACE = 4'd1,
    BC_ALPHA = 4'd2,
    BC_END   = 4'd3,
    BC_PLUS  = 4'd4,
    BC_MINUS = 4'd5,
    BC_STAR  = 4'd6,
    BC_SLASH = 4'd7,
    BC_OPEN  = 4'd8,
    BC_CLOSE = 4'd9,
    BC_BANG  = 4'd10,
    BC_AMP   = 4'd11,
    BC_PIPE  = 4'd12,
    BC_EQ    = 4'd13,
    BC_OTHER = 4'd14
  } bcls_t;

  typedef enum logic [3:0] {
    K_NUMBER  = 4'd0,
    K_SPACE   = 4'd1,
    K_WORD    = 4'd2,
    K_PLUS    = 4'd3,
    K_MINUS   = 4'd4,
    K_STAR    = 4'd5,
    K_SLASH   = 4'd6,
    K_OPEN    = 4'd7,
    K_CLOSE   = 4'd8,
    K_BANG    = 4'd9,
    K_BANG_EQ = 4'd10,
    K_ANDAND  = 4'd11,
    K_OROR    = 4'd12,
    K_EQEQ    = 4'd13,
    K_BAD     = 4'd14,
    K_END     = 4'd15
  } kind_t;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE  = 2'd1;
  localparam logic [1:0] ST_UNEXPECTED = 2'd2;

  // Pending token class held by the back.
  typedef enum logic [7:0] {
    PC_IDLE   = 8'b0000_0001,
    PC_NUMBER = 8'b0000_0010,
    PC_SPACE  = 8'b0000_0100,
    PC_WORD   = 8'b0000_1000,
    PC_BANG   = 8'b0001_0000,
    PC_AMP    = 8'b0010_0000,
    PC_PIPE   = 8'b0100_0000,
    PC_EQ     = 8'b1000_0000
  } pend_t;

  // Classified byte, front to back.
  typedef struct packed {
    bcls_t      cls;
    logic [3:0] digit;
  } byte_item_t;

  // One result token.
  typedef struct packed {
    kind_t                  kind;
    logic [15:0]            start;
    logic [15:0]            length;
    logic [VALUE_BITS-1:0]  value;
    logic [1:0]             status;
    logic                   last;
  } tok_t;

endpackage

`default_nettype wire

>>> rtl/core/etl_front.sv
// ============================================================================
// etl_front - byte classifier, position counter and byte queue
// Accepts one source byte per cycle while its queue has room, tags it with its
// class and offset and holds it in a short queue until the back takes it.
// ============================================================================
`default_nettype none

module etl_front #(
  parameter int POSITION_BITS = etl_pkg::POSITION_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_push,
  input  wire logic [7:0]               in_ch,
  output logic                          in_full,
  output logic                          q_valid,
  output etl_pkg::byte_item_t           q_item,
  output logic [POSITION_BITS-1:0]      q_pos,
  input  wire logic                     q_pop
);

  localparam int DEPTH = etl_pkg::BYTE_Q_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  etl_pkg::byte_item_t          item_mem [DEPTH];
  logic [POSITION_BITS-1:0]     pos_mem  [DEPTH];
  logic [AW-1:0]                wptr_r, rptr_r;
  logic [AW:0]                  count_r, count_nxt;
  logic [POSITION_BITS-1:0]     pos_r, pos_nxt;
  etl_pkg::byte_item_t          cls_item;
  logic                         push_ok;

  // Classify the byte.
  always_comb begin
    cls_item.digit = in_ch[3:0];
    if (in_ch >= 8'h30 && in_ch <= 8'h39) begin
      cls_item.cls = etl_pkg::BC_DIGIT;
    end else if (in_ch == 8'h20 || (in_ch >= 8'h09 && in_ch <= 8'h0d)) begin
      cls_item.cls = etl_pkg::BC_SPACE;
    end else if ((in_ch >= 8'h41 && in_ch <= 8'h5a) ||
                 (in_ch >= 8'h61 && in_ch <= 8'h7a)) begin
      cls_item.cls = etl_pkg::BC_ALPHA;
    end else begin
      unique case (in_ch)
        8'h00:   cls_item.cls = etl_pkg::BC_END;
        8'h2b:   cls_item.cls = etl_pkg::BC_PLUS;
        8'h2d:   cls_item.cls = etl_pkg::BC_MINUS;
        8'h2a:   cls_item.cls = etl_pkg::BC_STAR;
        8'h2f:   cls_item.cls = etl_pkg::BC_SLASH;
        8'h28:   cls_item.cls = etl_pkg::BC_OPEN;
        8'h29:   cls_item.cls = etl_pkg::BC_CLOSE;
        8'h21:   cls_item.cls = etl_pkg::BC_BANG;
        8'h26:   cls_item.cls = etl_pkg::BC_AMP;
        8'h7c:   cls_item.cls = etl_pkg::BC_PIPE;
        8'h3d:   cls_item.cls = etl_pkg::BC_EQ;
        default: cls_item.cls = etl_pkg::BC_OTHER;
      endcase
    end
  end

  assign in_full = (count_r == (AW+1)'(DEPTH));
  assign push_ok = in_push && !in_full;
  assign q_valid = (count_r != '0);
  assign q_item  = item_mem[rptr_r];
  assign q_pos   = pos_mem[rptr_r];

  // Saturate the offset; restart it after end of source.
  always_comb begin
    if (cls_item.cls == etl_pkg::BC_END) begin
      pos_nxt = '0;
    end else if (pos_r == {POSITION_BITS{1'b1}}) begin
      pos_nxt = pos_r;
    end else begin
      pos_nxt = pos_r + 1'b1;
    end
  end

  always_comb begin
    count_nxt = count_r + (AW+1)'(push_ok) - (AW+1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (push_ok) begin
        pos_r  <= pos_nxt;
        wptr_r <= wptr_r + 1'b1;
      end
      if (q_pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      item_mem[wptr_r] <= cls_item;
      pos_mem[wptr_r]  <= pos_r;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/etl_back.sv
// ============================================================================
// etl_back - token state machine
// Resolves the pending token against each classified byte, accumulates digit
// runs and produces zero, one or two tokens per byte.
// ============================================================================
`default_nettype none

module etl_back #(
  parameter int POSITION_BITS = etl_pkg::POSITION_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     q_valid,
  input  wire etl_pkg::byte_item_t      q_item,
  input  wire logic [POSITION_BITS-1:0] q_pos,
  output logic                          q_pop,
  input  wire logic                     res_room,
  output logic [1:0]                    wr_n,
  output etl_pkg::tok_t                 wr_tok0,
  output etl_pkg::tok_t                 wr_tok1
);

  localparam int VB = etl_pkg::VALUE_BITS;

  etl_pkg::pend_t               pend_r, pend_nxt;
  logic [POSITION_BITS-1:0]     begin_r, begin_nxt;
  logic [VB-1:0]                acc_r, acc_nxt;
  logic                         ovf_r, ovf_nxt;
  logic                         go;
  logic [POSITION_BITS-1:0]     run_len;
  logic [POSITION_BITS+15:0]    run_len_ext, begin_ext, pos_ext;
  logic [VB+3:0]                prod;
  logic                         res_v, own_v, handle_own;
  etl_pkg::tok_t                res_tok, own_tok;

  assign go    = q_valid && res_room;
  assign q_pop = go;

  assign run_len     = q_pos - begin_r;
  assign run_len_ext = {16'd0, run_len};
  assign begin_ext   = {16'd0, begin_r};
  assign pos_ext     = {16'd0, q_pos};

  // acc * 10 + digit, widened so that overflow shows in the top bits.
  assign prod = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1) + (VB+4)'(q_item.digit);

  always_comb begin
    pend_nxt   = pend_r;
    begin_nxt  = begin_r;
    acc_nxt    = acc_r;
    ovf_nxt    = ovf_r;
    res_v      = 1'b0;
    own_v      = 1'b0;
    handle_own = 1'b1;
    res_tok        = '0;
    res_tok.kind   = etl_pkg::K_BAD;
    res_tok.start  = begin_ext[15:0];
    res_tok.length = run_len_ext[15:0];
    own_tok        = '0;
    own_tok.kind   = etl_pkg::K_BAD;
    own_tok.start  = pos_ext[15:0];
    own_tok.length = 16'd1;

    unique case (pend_r)
      etl_pkg::PC_NUMBER: begin
        if (q_item.cls == etl_pkg::BC_DIGIT) begin
          handle_own = 1'b0;
          if (!ovf_r) begin
            if (prod[VB+3:VB] != 4'd0) begin
              ovf_nxt = 1'b1;
              acc_nxt = '0;
            end else begin
              acc_nxt = prod[VB-1:0];
            end
          end
        end else begin
          res_v          = 1'b1;
          res_tok.kind   = etl_pkg::K_NUMBER;
          res_tok.value  = ovf_r ? '0 : acc_r;
          res_tok.status = ovf_r ? etl_pkg::ST_TOO_LARGE : etl_pkg::ST_OK;
          pend_nxt       = etl_pkg::PC_IDLE;
        end
      end
      etl_pkg::PC_SPACE: begin
        if (q_item.cls == etl_pkg::BC_SPACE) begin
          handle_own = 1'b0;
        end else begin
          res_v        = 1'b1;
          res_tok.kind = etl_pkg::K_SPACE;
          pend_nxt     = etl_pkg::PC_IDLE;
        end
      end
      etl_pkg::PC_WORD: begin
        if (q_item.cls == etl_pkg::BC_ALPHA) begin
          handle_own = 1'b0;
        end else begin
          res_v        = 1'b1;
          res_tok.kind = etl_pkg::K_WORD;
          pend_nxt     = etl_pkg::PC_IDLE;
        end
      end
      etl_pkg::PC_BANG, etl_pkg::PC_AMP, etl_pkg::PC_PIPE, etl_pkg::PC_EQ: begin
        res_v    = 1'b1;
        pend_nxt = etl_pkg::PC_IDLE;
        if ((pend_r == etl_pkg::PC_BANG || pend_r == etl_pkg::PC_EQ) &&
            q_item.cls == etl_pkg::BC_EQ) begin
          handle_own     = 1'b0;
          res_tok.length = 16'd2;
          res_tok.kind   = (pend_r == etl_pkg::PC_BANG) ? etl_pkg::K_BANG_EQ
                                                        : etl_pkg::K_EQEQ;
        end else if (pend_r == etl_pkg::PC_AMP && q_item.cls == etl_pkg::BC_AMP) begin
          handle_own     = 1'b0;
          res_tok.length = 16'd2;
          res_tok.kind   = etl_pkg::K_ANDAND;
        end else if (pend_r == etl_pkg::PC_PIPE && q_item.cls == etl_pkg::BC_PIPE) begin
          handle_own     = 1'b0;
          res_tok.length = 16'd2;
          res_tok.kind   = etl_pkg::K_OROR;
        end else begin
          res_tok.length = 16'd1;
          if (pend_r == etl_pkg::PC_BANG) begin
            res_tok.kind = etl_pkg::K_BANG;
          end else begin
            res_tok.kind   = etl_pkg::K_BAD;
            res_tok.status = etl_pkg::ST_UNEXPECTED;
          end
        end
      end
      default: begin
      end
    endcase

    if (handle_own) begin
      unique case (q_item.cls)
        etl_pkg::BC_END: begin
          own_v          = 1'b1;
          own_tok.kind   = etl_pkg::K_END;
          own_tok.length = 16'd0;
          pend_nxt       = etl_pkg::PC_IDLE;
          begin_nxt      = '0;
          acc_nxt        = '0;
          ovf_nxt        = 1'b0;
        end
        etl_pkg::BC_DIGIT: begin
          pend_nxt  = etl_pkg::PC_NUMBER;
          begin_nxt = q_pos;
          acc_nxt   = VB'(q_item.digit);
          ovf_nxt   = 1'b0;
        end
        etl_pkg::BC_SPACE: begin
          pend_nxt  = etl_pkg::PC_SPACE;
          begin_nxt = q_pos;
        end
        etl_pkg::BC_ALPHA: begin
          pend_nxt  = etl_pkg::PC_WORD;
          begin_nxt = q_pos;
        end
        etl_pkg::BC_BANG: begin
          pend_nxt  = etl_pkg::PC_BANG;
          begin_nxt = q_pos;
        end
        etl_pkg::BC_AMP: begin
          pend_nxt  = etl_pkg::PC_AMP;
          begin_nxt = q_pos;
        end
        etl_pkg::BC_PIPE: begin
          pend_nxt  = etl_pkg::PC_PIPE;
          begin_nxt = q_pos;
        end
        etl_pkg::BC_EQ: begin
          pend_nxt  = etl_pkg::PC_EQ;
          begin_nxt = q_pos;
        end
        etl_pkg::BC_PLUS: begin
          own_v        = 1'b1;
          own_tok.kind = etl_pkg::K_PLUS;
        end
        etl_pkg::BC_MINUS: begin
          own_v        = 1'b1;
          own_tok.kind = etl_pkg::K_MINUS;
        end
        etl_pkg::BC_STAR: begin
          own_v        = 1'b1;
          own_tok.kind = etl_pkg::K_STAR;
        end
        etl_pkg::BC_SLASH: begin
          own_v        = 1'b1;
          own_tok.kind = etl_pkg::K_SLASH;
        end
        etl_pkg::BC_OPEN: begin
          own_v        = 1'b1;
          own_tok.kind = etl_pkg::K_OPEN;
        end
        etl_pkg::BC_CLOSE: begin
          own_v        = 1'b1;
          own_tok.kind = etl_pkg::K_CLOSE;
        end
        default: begin
          own_v          = 1'b1;
          own_tok.kind   = etl_pkg::K_BAD;
          own_tok.status = etl_pkg::ST_UNEXPECTED;
        end
      endcase
    end
  end

  // Pack the tokens in order; the final one carries last.
  always_comb begin
    wr_tok0      = res_v ? res_tok : own_tok;
    wr_tok0.last = !(res_v && own_v);
    wr_tok1      = own_tok;
    wr_tok1.last = 1'b1;
    if (go) begin
      wr_n = {1'b0, res_v} + {1'b0, own_v};
    end else begin
      wr_n = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= etl_pkg::PC_IDLE;
      begin_r <= '0;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
    end else if (go) begin
      pend_r  <= pend_nxt;
      begin_r <= begin_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    go && q_item.cls == etl_pkg::BC_END |=> pend_r == etl_pkg::PC_IDLE && !ovf_r)
    else $error("state not cleared after end of source");

  a_ovf_acc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> acc_r == '0)
    else $error("accumulator nonzero while overflowed");

  a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    wr_n == 2'd2 |-> !wr_tok0.last && wr_tok1.last && wr_tok0.kind != etl_pkg::K_END)
    else $error("bad ordering of two tokens from one byte");

endmodule

`default_nettype wire

>>> rtl/core/etl_result_fifo.sv
// ============================================================================
// etl_result_fifo - result token queue
// Takes up to two tokens per cycle from the back and hands out one per pop.
// ============================================================================
`default_nettype none

module etl_result_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [1:0]     wr_n,
  input  wire etl_pkg::tok_t  wr_tok0,
  input  wire etl_pkg::tok_t  wr_tok1,
  output logic                room,
  output logic                empty,
  input  wire logic           pop,
  output etl_pkg::tok_t       head
);

  localparam int DEPTH = etl_pkg::RES_Q_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  etl_pkg::tok_t   mem [DEPTH];
  logic [AW-1:0]   wptr_r, rptr_r, wptr_p1;
  logic [AW:0]     count_r;
  logic            rd;

  assign empty   = (count_r == '0);
  assign rd      = pop && !empty;
  // Room for a full pair of tokens.
  assign room    = (count_r <= (AW+1)'(DEPTH - 2));
  assign head    = mem[rptr_r];
  assign wptr_p1 = wptr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_r + (AW+1)'(wr_n) - (AW+1)'(rd);
      wptr_r  <= wptr_r + AW'(wr_n);
      if (rd) begin
        rptr_r <= rptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_n != 2'd0) begin
      mem[wptr_r] <= wr_tok0;
    end
    if (wr_n == 2'd2) begin
      mem[wptr_p1] <= wr_tok1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/expression_token_lexer.sv
// ============================================================================
// expression_token_lexer - streaming tokenizer for a small expression language
// Lexes one source byte per cycle, unless stalled, into number, space, word,
// operator, bad and end tokens, with a decimal value and overflow status for numbers.
// ============================================================================
//
//  Channel  Direction  Handshake            Payload
//  -------  ---------  -------------------  ----------------------------------
//  in_      input      in_push / in_full    in_ch
//  out_     output     out_empty / out_pop  out_token_kind, out_token_start,
//                                           out_token_length, out_number_value,
//                                           out_status, out_last
//
//  Flow: one byte per cycle while the back is not stalled; a token reaches the
//  result ports once the byte that completes it is accepted and has passed the
//  byte queue and the back has written the token into the result queue. Runs
//  and ! & | = complete only when the following byte arrives.
//  The back's per-byte step is a pending-token resolve plus acc*10+digit.
//  A byte may yield two tokens; output drain of one per cycle then bounds rate.
//  Reset: synchronous, active low; clears queues and lexer state.
//  Stalls: the back holds when the result queue has room for fewer than two
//  tokens; the front keeps accepting until its byte queue is full.
//
`default_nettype none

module expression_token_lexer #(
  parameter int POSITION_BITS = etl_pkg::POSITION_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_push,
  input  wire logic [7:0]   in_ch,
  output logic              in_full,
  output logic              out_empty,
  input  wire logic         out_pop,
  output logic [3:0]        out_token_kind,
  output logic [15:0]       out_token_start,
  output logic [15:0]       out_token_length,
  output logic [62:0]       out_number_value,
  output logic [1:0]        out_status,
  output logic              out_last
);

  // Front to back: classified byte and its offset.
  logic                         q_valid;
  logic                         q_pop;
  etl_pkg::byte_item_t          q_item;
  logic [POSITION_BITS-1:0]     q_pos;

  // Back to result queue.
  logic                         res_room;
  logic [1:0]                   wr_n;
  etl_pkg::tok_t                wr_tok0, wr_tok1;
  etl_pkg::tok_t                head;

  // Classify each byte and advance the offset.
  etl_front #(
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_ch   (in_ch),
    .in_full (in_full),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pos   (q_pos),
    .q_pop   (q_pop)
  );

  // Resolve pending tokens; advance only when two result slots are free.
  etl_back #(
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pos    (q_pos),
    .q_pop    (q_pop),
    .res_room (res_room),
    .wr_n     (wr_n),
    .wr_tok0  (wr_tok0),
    .wr_tok1  (wr_tok1)
  );

  // Hold finished tokens until the consumer pops each transaction.
  etl_result_fifo u_res (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_n    (wr_n),
    .wr_tok0 (wr_tok0),
    .wr_tok1 (wr_tok1),
    .room    (res_room),
    .empty   (out_empty),
    .pop     (out_pop),
    .head    (head)
  );

  assign out_token_kind   = head.kind;
  assign out_token_start  = head.start;
  assign out_token_length = head.length;
  assign out_number_value = head.value;
  assign out_status       = head.status;
  assign out_last         = head.last;

endmodule

`default_nettype wire
